// File: hw/rtl/sipd_pkg.sv
package sipd_pkg;

    localparam int SLOTS           = 42;
    localparam int TERMS           = 21;
    localparam int SLOT_W          = 6;
    localparam int COORD_W         = 32;
    localparam int OFF_W           = 33;
    localparam int COEF_W          = 48;
    localparam int COEF_LO_W       = 20;
    localparam int CH_W            = COEF_W - COEF_LO_W;
    localparam int CL_W            = COEF_LO_W + 1;
    localparam int NORM_W          = 32;
    localparam int PH_W            = CH_W + NORM_W;
    localparam int PL_W            = CL_W + NORM_W;
    localparam int TERM_W          = 39;
    localparam int SUM_W           = 48;
    localparam int ACC_W           = 56;
    localparam int ORDER_W         = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int MAX_DEGREE_DEF  = 5;
    localparam int COORD_SHIFT_DEF = 15;

    localparam logic signed [NORM_W-1:0] ONE_Q30 = 32'sh4000_0000;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_XFORM = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_REF  = 2'd0,
        REG_Y_REF  = 2'd1,
        REG_ORDER  = 2'd2,
        REG_Y_FLIP = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              vld;
        logic              load;
        logic [SLOT_W-1:0] slot;
    } lane_ctl_t;

    function automatic int term_deg(input int t);
        int d;
        d = 0;
        for (int k = 1; k <= 5; k++)
        begin
            if (t >= k * (k + 1) / 2)
            begin
                d = k;
            end
        end
        return d;
    endfunction

    function automatic int term_j(input int t);
        int d;
        d = term_deg(t);
        return t - d * (d + 1) / 2;
    endfunction

    function automatic logic signed [NORM_W-1:0] mul_q30(
        input logic signed [NORM_W-1:0] a,
        input logic signed [NORM_W-1:0] b
    );
        logic signed [2*NORM_W-1:0] p;
        p = a * b;
        return p[30 +: NORM_W];
    endfunction

endpackage

// File: hw/rtl/sip_polynomial_distortion.sv
// Throughput: one item per cycle while out_ready does not stall the output, set by the
// fully pipelined power, monomial, coefficient multiply and adder-tree stages; loads
// take one slot and give no result.
// Reset: asynchronous, active low; clears all pipeline valid bits, the coefficient table
// to zero (identity mapping), both references to zero, order to one and y flip to zero.
module sip_polynomial_distortion #(
    parameter int MAX_DEGREE  = sipd_pkg::MAX_DEGREE_DEF,
    parameter int COORD_SHIFT = sipd_pkg::COORD_SHIFT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [sipd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [sipd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  command,
    input  logic        [sipd_pkg::SLOT_W-1:0]    coef_slot,
    input  logic signed [sipd_pkg::COEF_W-1:0]    coef_value,
    input  logic signed [sipd_pkg::COORD_W-1:0]   x_in,
    input  logic signed [sipd_pkg::COORD_W-1:0]   y_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sipd_pkg::COORD_W-1:0]   x_out,
    output logic signed [sipd_pkg::COORD_W-1:0]   y_out,
    output logic                                  saturated
);
    import sipd_pkg::*;

    logic signed [COORD_W-1:0]  x_ref_reg;
    logic signed [COORD_W-1:0]  y_ref_reg;
    logic [ORDER_W-1:0]         order_reg;
    logic                       y_flip_reg;
    logic [ORDER_W-1:0]         order_eff;

    lane_ctl_t                  f_ctl;
    logic signed [COEF_W-1:0]   f_value;
    logic signed [OFF_W-1:0]    f_u;
    logic signed [OFF_W-1:0]    f_v;
    logic signed [NORM_W-1:0]   f_mono [TERMS];
    logic                       t_ready;
    logic                       t_vld;
    logic signed [OFF_W-1:0]    t_u;
    logic signed [OFF_W-1:0]    t_v;
    logic signed [TERM_W-1:0]   t_tx [TERMS];
    logic signed [TERM_W-1:0]   t_ty [TERMS];
    logic                       s_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_ref_reg  <= '0;
            y_ref_reg  <= '0;
            order_reg  <= ORDER_W'(1);
            y_flip_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_X_REF:  x_ref_reg  <= cfg_data;
                REG_Y_REF:  y_ref_reg  <= cfg_data;
                REG_ORDER:  order_reg  <= cfg_data[ORDER_W-1:0];
                REG_Y_FLIP: y_flip_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (order_reg < ORDER_W'(1))
        begin
            order_eff = ORDER_W'(1);
        end
        else if (order_reg > ORDER_W'(MAX_DEGREE))
        begin
            order_eff = ORDER_W'(MAX_DEGREE);
        end
        else
        begin
            order_eff = order_reg;
        end
    end

    sipd_front #(
        .MAX_DEGREE  (MAX_DEGREE),
        .COORD_SHIFT (COORD_SHIFT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .coef_slot  (coef_slot),
        .coef_value (coef_value),
        .x_in       (x_in),
        .y_in       (y_in),
        .x_ref      (x_ref_reg),
        .y_ref      (y_ref_reg),
        .y_flip     (y_flip_reg),
        .dn_ctl     (f_ctl),
        .dn_value   (f_value),
        .dn_u       (f_u),
        .dn_v       (f_v),
        .dn_mono    (f_mono),
        .dn_ready   (t_ready)
    );

    sipd_terms #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_ctl    (f_ctl),
        .up_value  (f_value),
        .up_u      (f_u),
        .up_v      (f_v),
        .up_mono   (f_mono),
        .order_eff (order_eff),
        .up_ready  (t_ready),
        .dn_vld    (t_vld),
        .dn_u      (t_u),
        .dn_v      (t_v),
        .dn_tx     (t_tx),
        .dn_ty     (t_ty),
        .dn_ready  (s_ready)
    );

    sipd_sum #(
        .MAX_DEGREE  (MAX_DEGREE),
        .COORD_SHIFT (COORD_SHIFT)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_vld    (t_vld),
        .up_ready  (s_ready),
        .up_u      (t_u),
        .up_v      (t_v),
        .up_tx     (t_tx),
        .up_ty     (t_ty),
        .x_ref     (x_ref_reg),
        .y_ref     (y_ref_reg),
        .y_flip    (y_flip_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .x_out     (x_out),
        .y_out     (y_out),
        .saturated (saturated)
    );

`ifndef ASSERT_OFF
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output side is ready");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (x_out == 32'sh7FFF_FFFF || x_out == 32'sh8000_0000 ||
             y_out == 32'sh7FFF_FFFF || y_out == 32'sh8000_0000))
        else $error("saturation flag without a clipped coordinate");

    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        (order_eff >= ORDER_W'(1)) && (order_eff <= ORDER_W'(MAX_DEGREE)))
        else $error("effective order out of range");
`endif

endmodule

// File: hw/rtl/sipd_front.sv
module sipd_front #(
    parameter int MAX_DEGREE  = sipd_pkg::MAX_DEGREE_DEF,
    parameter int COORD_SHIFT = sipd_pkg::COORD_SHIFT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  command,
    input  logic        [sipd_pkg::SLOT_W-1:0]    coef_slot,
    input  logic signed [sipd_pkg::COEF_W-1:0]    coef_value,
    input  logic signed [sipd_pkg::COORD_W-1:0]   x_in,
    input  logic signed [sipd_pkg::COORD_W-1:0]   y_in,
    input  logic signed [sipd_pkg::COORD_W-1:0]   x_ref,
    input  logic signed [sipd_pkg::COORD_W-1:0]   y_ref,
    input  logic                                  y_flip,
    output sipd_pkg::lane_ctl_t                   dn_ctl,
    output logic signed [sipd_pkg::COEF_W-1:0]    dn_value,
    output logic signed [sipd_pkg::OFF_W-1:0]     dn_u,
    output logic signed [sipd_pkg::OFF_W-1:0]     dn_v,
    output logic signed [sipd_pkg::NORM_W-1:0]    dn_mono [sipd_pkg::TERMS],
    input  logic                                  dn_ready
);
    import sipd_pkg::*;

    localparam int NF     = MAX_DEGREE + 2;
    localparam int LAST   = NF - 1;
    localparam int NT     = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
    localparam int NSH    = 14 - COORD_SHIFT;
    localparam int NSH_L  = (NSH >= 0) ? NSH : 0;
    localparam int NSH_R  = (NSH < 0) ? -NSH : 0;
    localparam int WIDE_W = OFF_W + 7;

    logic                       vld_reg  [NF];
    logic                       rdy      [NF+1];
    logic                       load_reg [NF];
    logic [SLOT_W-1:0]          slot_reg [NF];
    logic signed [COEF_W-1:0]   val_reg  [NF];
    logic signed [OFF_W-1:0]    u_reg    [NF];
    logic signed [OFF_W-1:0]    v_reg    [NF];
    logic signed [NORM_W-1:0]   pu_reg   [NF][MAX_DEGREE+1];
    logic signed [NORM_W-1:0]   pv_reg   [NF][MAX_DEGREE+1];
    logic signed [NORM_W-1:0]   mono_reg [NT];
    logic signed [OFF_W-1:0]    u_off;
    logic signed [OFF_W-1:0]    v_off;

    function automatic logic signed [NORM_W-1:0] norm_q30(input logic signed [OFF_W-1:0] off);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(off);
        w = (w <<< NSH_L) >>> NSH_R;
        if (w > WIDE_W'(ONE_Q30))
        begin
            return ONE_Q30;
        end
        else if (w < -WIDE_W'(ONE_Q30))
        begin
            return -ONE_Q30;
        end
        return w[NORM_W-1:0];
    endfunction

    always_comb
    begin
        rdy[NF] = dn_ready;
        for (int k = NF - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        u_off = OFF_W'(x_in) - OFF_W'(x_ref);
        if (y_flip)
        begin
            v_off = OFF_W'(y_ref) - OFF_W'(y_in);
        end
        else
        begin
            v_off = OFF_W'(y_in) - OFF_W'(y_ref);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NF; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NF; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            load_reg[0] <= (command == CMD_LOAD);
            slot_reg[0] <= coef_slot;
            val_reg[0]  <= coef_value;
            u_reg[0]    <= u_off;
            v_reg[0]    <= v_off;
        end
        for (int k = 1; k < NF; k++)
        begin
            if (rdy[k])
            begin
                load_reg[k] <= load_reg[k-1];
                slot_reg[k] <= slot_reg[k-1];
                val_reg[k]  <= val_reg[k-1];
                u_reg[k]    <= u_reg[k-1];
                v_reg[k]    <= v_reg[k-1];
            end
        end
        if (rdy[1])
        begin
            pu_reg[1][0] <= ONE_Q30;
            pv_reg[1][0] <= ONE_Q30;
            pu_reg[1][1] <= norm_q30(u_reg[0]);
            pv_reg[1][1] <= norm_q30(v_reg[0]);
        end
        for (int k = 2; k <= MAX_DEGREE; k++)
        begin
            if (rdy[k])
            begin
                for (int i = 0; i <= MAX_DEGREE; i++)
                begin
                    if (i < k)
                    begin
                        pu_reg[k][i] <= pu_reg[k-1][i];
                        pv_reg[k][i] <= pv_reg[k-1][i];
                    end
                    else if (i == k)
                    begin
                        pu_reg[k][i] <= mul_q30(pu_reg[k-1][k-1], pu_reg[k-1][1]);
                        pv_reg[k][i] <= mul_q30(pv_reg[k-1][k-1], pv_reg[k-1][1]);
                    end
                end
            end
        end
        if (rdy[LAST])
        begin
            for (int t = 0; t < NT; t++)
            begin
                mono_reg[t] <= mul_q30(pu_reg[MAX_DEGREE][term_deg(t) - term_j(t)],
                                       pv_reg[MAX_DEGREE][term_j(t)]);
            end
        end
    end

    assign dn_ctl.vld  = vld_reg[LAST];
    assign dn_ctl.load = load_reg[LAST];
    assign dn_ctl.slot = slot_reg[LAST];
    assign dn_value    = val_reg[LAST];
    assign dn_u        = u_reg[LAST];
    assign dn_v        = v_reg[LAST];

    for (genvar t = 0; t < TERMS; t++)
    begin : g_mono
        if (t < NT)
        begin : g_used
            assign dn_mono[t] = mono_reg[t];
        end
        else
        begin : g_zero
            assign dn_mono[t] = '0;
        end
    end

endmodule

// File: hw/rtl/sipd_terms.sv
module sipd_terms #(
    parameter int MAX_DEGREE = sipd_pkg::MAX_DEGREE_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sipd_pkg::lane_ctl_t                   up_ctl,
    input  logic signed [sipd_pkg::COEF_W-1:0]    up_value,
    input  logic signed [sipd_pkg::OFF_W-1:0]     up_u,
    input  logic signed [sipd_pkg::OFF_W-1:0]     up_v,
    input  logic signed [sipd_pkg::NORM_W-1:0]    up_mono [sipd_pkg::TERMS],
    input  logic        [sipd_pkg::ORDER_W-1:0]   order_eff,
    output logic                                  up_ready,
    output logic                                  dn_vld,
    output logic signed [sipd_pkg::OFF_W-1:0]     dn_u,
    output logic signed [sipd_pkg::OFF_W-1:0]     dn_v,
    output logic signed [sipd_pkg::TERM_W-1:0]    dn_tx [sipd_pkg::TERMS],
    output logic signed [sipd_pkg::TERM_W-1:0]    dn_ty [sipd_pkg::TERMS],
    input  logic                                  dn_ready
);
    import sipd_pkg::*;

    localparam int NT = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;

    logic                       vld_reg  [2];
    logic                       rdy      [3];
    logic signed [COEF_W-1:0]   coef_reg [SLOTS];
    logic signed [PH_W-1:0]     phx_reg  [NT];
    logic signed [PL_W-1:0]     plx_reg  [NT];
    logic signed [PH_W-1:0]     phy_reg  [NT];
    logic signed [PL_W-1:0]     ply_reg  [NT];
    logic                       en_reg   [NT];
    logic signed [TERM_W-1:0]   tx_reg   [NT];
    logic signed [TERM_W-1:0]   ty_reg   [NT];
    logic signed [OFF_W-1:0]    u_reg    [2];
    logic signed [OFF_W-1:0]    v_reg    [2];
    logic                       wr;

    function automatic logic signed [TERM_W-1:0] term_of(
        input logic signed [PH_W-1:0] ph,
        input logic signed [PL_W-1:0] pl
    );
        logic signed [PH_W-1:0] s;
        s = ph + PH_W'(pl >>> COEF_LO_W);
        return s[COEF_LO_W +: TERM_W];
    endfunction

    assign rdy[2]   = dn_ready;
    assign rdy[1]   = !vld_reg[1] || rdy[2];
    assign rdy[0]   = !vld_reg[0] || rdy[1];
    assign up_ready = rdy[0];

    assign wr = up_ctl.vld && up_ctl.load && rdy[0] && (up_ctl.slot < SLOT_W'(SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
            for (int s = 0; s < SLOTS; s++)
            begin
                coef_reg[s] <= '0;
            end
        end
        else
        begin
            if (wr)
            begin
                coef_reg[up_ctl.slot] <= up_value;
            end
            if (rdy[0])
            begin
                vld_reg[0] <= up_ctl.vld && !up_ctl.load;
            end
            if (rdy[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            u_reg[0] <= up_u;
            v_reg[0] <= up_v;
            for (int t = 0; t < NT; t++)
            begin
                phx_reg[t] <= $signed(coef_reg[t][COEF_W-1:COEF_LO_W]) * up_mono[t];
                plx_reg[t] <= $signed({1'b0, coef_reg[t][COEF_LO_W-1:0]}) * up_mono[t];
                phy_reg[t] <= $signed(coef_reg[TERMS+t][COEF_W-1:COEF_LO_W]) * up_mono[t];
                ply_reg[t] <= $signed({1'b0, coef_reg[TERMS+t][COEF_LO_W-1:0]}) * up_mono[t];
                en_reg[t]  <= (ORDER_W'(term_deg(t)) <= order_eff);
            end
        end
        if (rdy[1])
        begin
            u_reg[1] <= u_reg[0];
            v_reg[1] <= v_reg[0];
            for (int t = 0; t < NT; t++)
            begin
                tx_reg[t] <= en_reg[t] ? term_of(phx_reg[t], plx_reg[t]) : '0;
                ty_reg[t] <= en_reg[t] ? term_of(phy_reg[t], ply_reg[t]) : '0;
            end
        end
    end

    assign dn_vld = vld_reg[1];
    assign dn_u   = u_reg[1];
    assign dn_v   = v_reg[1];

    for (genvar t = 0; t < TERMS; t++)
    begin : g_term
        if (t < NT)
        begin : g_used
            assign dn_tx[t] = tx_reg[t];
            assign dn_ty[t] = ty_reg[t];
        end
        else
        begin : g_zero
            assign dn_tx[t] = '0;
            assign dn_ty[t] = '0;
        end
    end

endmodule

// File: hw/rtl/sipd_sum.sv
module sipd_sum #(
    parameter int MAX_DEGREE  = sipd_pkg::MAX_DEGREE_DEF,
    parameter int COORD_SHIFT = sipd_pkg::COORD_SHIFT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  up_vld,
    output logic                                  up_ready,
    input  logic signed [sipd_pkg::OFF_W-1:0]     up_u,
    input  logic signed [sipd_pkg::OFF_W-1:0]     up_v,
    input  logic signed [sipd_pkg::TERM_W-1:0]    up_tx [sipd_pkg::TERMS],
    input  logic signed [sipd_pkg::TERM_W-1:0]    up_ty [sipd_pkg::TERMS],
    input  logic signed [sipd_pkg::COORD_W-1:0]   x_ref,
    input  logic signed [sipd_pkg::COORD_W-1:0]   y_ref,
    input  logic                                  y_flip,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sipd_pkg::COORD_W-1:0]   x_out,
    output logic signed [sipd_pkg::COORD_W-1:0]   y_out,
    output logic                                  saturated
);
    import sipd_pkg::*;

    localparam int NT    = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
    localparam int L     = $clog2(NT);
    localparam int NP    = 1 << L;
    localparam int NS    = L + 2;
    localparam int SSH   = COORD_SHIFT - 14;
    localparam int SSH_L = (SSH >= 0) ? SSH : 0;
    localparam int SSH_R = (SSH < 0) ? -SSH : 0;

    localparam logic signed [ACC_W-1:0] MAXV = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] MINV = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

    logic                       vld_reg [NS];
    logic                       rdy     [NS+1];
    logic signed [SUM_W-1:0]    ax      [NP];
    logic signed [SUM_W-1:0]    ay      [NP];
    logic signed [SUM_W-1:0]    sx_reg  [L][NP/2];
    logic signed [SUM_W-1:0]    sy_reg  [L][NP/2];
    logic signed [OFF_W-1:0]    u_reg   [L];
    logic signed [OFF_W-1:0]    v_reg   [L];
    logic signed [ACC_W-1:0]    xa_reg;
    logic signed [ACC_W-1:0]    ya_reg;
    logic signed [ACC_W-1:0]    xs;
    logic signed [ACC_W-1:0]    ys;
    logic signed [COORD_W-1:0]  x_next;
    logic signed [COORD_W-1:0]  y_next;
    logic                       sat_next;
    logic signed [COORD_W-1:0]  x_out_reg;
    logic signed [COORD_W-1:0]  y_out_reg;
    logic                       sat_reg;

    for (genvar i = 0; i < NP; i++)
    begin : g_pad
        if (i < NT)
        begin : g_used
            assign ax[i] = SUM_W'(up_tx[i]);
            assign ay[i] = SUM_W'(up_ty[i]);
        end
        else
        begin : g_zero
            assign ax[i] = '0;
            assign ay[i] = '0;
        end
    end

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign up_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= up_vld;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            u_reg[0] <= up_u;
            v_reg[0] <= up_v;
            for (int i = 0; i < NP / 2; i++)
            begin
                sx_reg[0][i] <= ax[2*i] + ax[2*i+1];
                sy_reg[0][i] <= ay[2*i] + ay[2*i+1];
            end
        end
        for (int l = 1; l < L; l++)
        begin
            if (rdy[l])
            begin
                u_reg[l] <= u_reg[l-1];
                v_reg[l] <= v_reg[l-1];
                for (int i = 0; i < (NP >> (l + 1)); i++)
                begin
                    sx_reg[l][i] <= sx_reg[l-1][2*i] + sx_reg[l-1][2*i+1];
                    sy_reg[l][i] <= sy_reg[l-1][2*i] + sy_reg[l-1][2*i+1];
                end
            end
        end
        if (rdy[L])
        begin
            xa_reg <= ACC_W'(u_reg[L-1]) + ((ACC_W'(sx_reg[L-1][0]) <<< SSH_L) >>> SSH_R);
            ya_reg <= ACC_W'(v_reg[L-1]) + ((ACC_W'(sy_reg[L-1][0]) <<< SSH_L) >>> SSH_R);
        end
        if (rdy[L+1])
        begin
            x_out_reg <= x_next;
            y_out_reg <= y_next;
            sat_reg   <= sat_next;
        end
    end

    always_comb
    begin
        xs = xa_reg + ACC_W'(x_ref);
        if (y_flip)
        begin
            ys = ACC_W'(y_ref) - ya_reg;
        end
        else
        begin
            ys = ya_reg + ACC_W'(y_ref);
        end
        sat_next = 1'b0;
        if (xs > MAXV)
        begin
            x_next   = MAXV[COORD_W-1:0];
            sat_next = 1'b1;
        end
        else if (xs < MINV)
        begin
            x_next   = MINV[COORD_W-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            x_next = xs[COORD_W-1:0];
        end
        if (ys > MAXV)
        begin
            y_next   = MAXV[COORD_W-1:0];
            sat_next = 1'b1;
        end
        else if (ys < MINV)
        begin
            y_next   = MINV[COORD_W-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            y_next = ys[COORD_W-1:0];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign x_out     = x_out_reg;
    assign y_out     = y_out_reg;
    assign saturated = sat_reg;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import sipd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 40;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      sat;
    } point_t;

    class sip_board;
        logic signed [COEF_W-1:0] coefs[SLOTS];
        longint                   x_ref;
        longint                   y_ref;
        int unsigned              order;
        bit                       flip;
        point_t                   pending[$];
        int                       errors;
        int                       checked;
        int                       clipped;

        function new();
            foreach (coefs[i])
            begin
                coefs[i] = '0;
            end
            x_ref   = 0;
            y_ref   = 0;
            order   = 1;
            flip    = 0;
            errors  = 0;
            checked = 0;
            clipped = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_X_REF:  x_ref = longint'(signed'(data));
                REG_Y_REF:  y_ref = longint'(signed'(data));
                REG_ORDER:  order = data[ORDER_W-1:0];
                REG_Y_FLIP: flip  = data[0];
                default: ;
            endcase
        endfunction

        function longint to_unit(longint off);
            longint n;
            n = off >>> (COORD_SHIFT_DEF - 14);
            if (n > (longint'(1) <<< 30))
            begin
                n = longint'(1) <<< 30;
            end
            if (n < -(longint'(1) <<< 30))
            begin
                n = -(longint'(1) <<< 30);
            end
            return n;
        endfunction

        function longint weigh(longint c, longint m);
            longint ch;
            longint cl;
            ch = c >>> 20;
            cl = c - (ch <<< 20);
            return (ch * m + ((cl * m) >>> 20)) >>> 20;
        endfunction

        function longint clip(longint v, ref bit hit);
            if (v > 64'sd2147483647)
            begin
                hit = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                hit = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void note_input(logic cmd, logic [SLOT_W-1:0] slot,
                                 logic signed [COEF_W-1:0] val,
                                 logic signed [COORD_W-1:0] xi,
                                 logic signed [COORD_W-1:0] yi);
            longint pu[6];
            longint pv[6];
            longint uo;
            longint vo;
            longint un;
            longint vn;
            longint sx;
            longint sy;
            longint m;
            longint xr;
            longint yr;
            int     ord;
            bit     hit;
            point_t p;
            if (cmd == CMD_LOAD)
            begin
                if (slot < SLOTS)
                begin
                    coefs[slot] = val;
                end
                return;
            end
            uo = longint'(xi) - x_ref;
            vo = flip ? y_ref - longint'(yi) : longint'(yi) - y_ref;
            un = to_unit(uo);
            vn = to_unit(vo);
            pu[0] = longint'(1) <<< 30;
            pv[0] = pu[0];
            for (int k = 1; k < 6; k++)
            begin
                pu[k] = (pu[k-1] * un) >>> 30;
                pv[k] = (pv[k-1] * vn) >>> 30;
            end
            ord = (order < 1) ? 1 : order;
            if (ord > MAX_DEGREE_DEF)
            begin
                ord = MAX_DEGREE_DEF;
            end
            sx = 0;
            sy = 0;
            for (int d = 0; d <= ord; d++)
            begin
                for (int j = 0; j <= d; j++)
                begin
                    m  = (pu[d-j] * pv[j]) >>> 30;
                    sx += weigh(longint'(coefs[d*(d+1)/2 + j]), m);
                    sy += weigh(longint'(coefs[TERMS + d*(d+1)/2 + j]), m);
                end
            end
            xr  = uo + (sx <<< (COORD_SHIFT_DEF - 14));
            yr  = vo + (sy <<< (COORD_SHIFT_DEF - 14));
            hit = 0;
            p.x = clip(xr + x_ref, hit);
            p.y = clip(flip ? y_ref - yr : yr + y_ref, hit);
            p.sat = hit;
            pending.push_back(p);
        endfunction

        function void check(logic signed [COORD_W-1:0] xo, logic signed [COORD_W-1:0] yo,
                            logic so);
            point_t p;
            if (pending.size() == 0)
            begin
                $error("unexpected result x_out=%0d y_out=%0d saturated=%0b", xo, yo, so);
                errors++;
                return;
            end
            p = pending.pop_front();
            checked++;
            if (so === 1'b1)
            begin
                clipped++;
            end
            if (xo !== p.x)
            begin
                $error("x_out expected %0d actual %0d", p.x, xo);
                errors++;
            end
            if (yo !== p.y)
            begin
                $error("y_out expected %0d actual %0d", p.y, yo);
                errors++;
            end
            if (so !== p.sat)
            begin
                $error("saturated expected %0b actual %0b", p.sat, so);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic                        command;
    logic [SLOT_W-1:0]           coef_slot;
    logic signed [COEF_W-1:0]    coef_value;
    logic signed [COORD_W-1:0]   x_in;
    logic signed [COORD_W-1:0]   y_in;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [COORD_W-1:0]   x_out;
    logic signed [COORD_W-1:0]   y_out;
    logic                        saturated;

    sip_board board;
    int       send_idle_pct;
    int       stall_pct;
    bit       hold_off;
    longint   cycles;
    int       sent;

    sip_polynomial_distortion dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .coef_slot  (coef_slot),
        .coef_value (coef_value),
        .x_in       (x_in),
        .y_in       (y_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .x_out      (x_out),
        .y_out      (y_out),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
        begin
            board.note_input(command, coef_slot, coef_value, x_in, y_in);
        end
        if (rst_n && out_valid && out_ready)
        begin
            board.check(x_out, y_out, saturated);
        end
    end

    always @(negedge clk)
    begin
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_item(logic cmd, logic [SLOT_W-1:0] slot, logic signed [COEF_W-1:0] val,
                             logic signed [COORD_W-1:0] xi, logic signed [COORD_W-1:0] yi);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        coef_slot  <= slot;
        coef_value <= val;
        x_in       <= xi;
        y_in       <= yi;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coef();
        logic signed [COEF_W-1:0] c;
        c = COEF_W'({$urandom(), $urandom()});
        case ($urandom_range(9))
            0, 1:    return c;
            2:       return $urandom_range(1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
            default: return c >>> $urandom_range(40, 8);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(longint centre);
        logic signed [COORD_W-1:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0, 1, 2: return r;
            3:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return COORD_W'(centre + longint'(r >>> $urandom_range(8, 0)));
        endcase
    endfunction

    task automatic random_items(int n);
        logic [SLOT_W-1:0] slot;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 30)
            begin
                slot = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(63, SLOTS))
                                                : SLOT_W'($urandom_range(SLOTS - 1));
                send_item(CMD_LOAD, slot, pick_coef(), $urandom(), $urandom());
            end
            else
            begin
                send_item(CMD_XFORM, SLOT_W'($urandom()), COEF_W'({$urandom(), $urandom()}),
                          pick_coord(board.x_ref), pick_coord(board.y_ref));
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic random_setup(int sel);
        cfg_write(REG_X_REF, (sel % 3 == 0) ? 32'h7FFF_FFFF : $urandom());
        cfg_write(REG_Y_REF, (sel % 3 == 1) ? 32'h8000_0000 : $urandom());
        cfg_write(REG_ORDER, CFG_DATA_W'(sel % 8));
        cfg_write(REG_Y_FLIP, CFG_DATA_W'(sel % 2));
    endtask

    initial
    begin
        board         = new();
        cycles        = 0;
        sent          = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off      = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = CMD_LOAD;
        coef_slot     = '0;
        coef_value    = '0;
        x_in          = '0;
        y_in          = '0;
        out_ready     = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(CMD_XFORM, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(CMD_XFORM, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(CMD_LOAD, 0, 48'sh7FFF_FFFF_FFFF, 0, 0);
        send_item(CMD_LOAD, 1, 48'sh8000_0000_0000, 0, 0);
        send_item(CMD_LOAD, 2, 48'sh000_0100_0000_0, 0, 0);
        send_item(CMD_LOAD, 20, 48'sh0000_4000_0000, 0, 0);
        send_item(CMD_LOAD, 21, 48'sh0000_0000_0001, 0, 0);
        send_item(CMD_LOAD, 41, 48'shFFFF_C000_0000, 0, 0);
        send_item(CMD_LOAD, SLOT_W'(SLOTS), 48'sh7FFF_FFFF_FFFF, 0, 0);
        send_item(CMD_LOAD, 63, 48'sh7FFF_FFFF_FFFF, 0, 0);
        send_item(CMD_XFORM, 0, 0, 0, 0);
        send_item(CMD_XFORM, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(CMD_XFORM, 0, 0, 32'sh8000_0000, 32'sh8000_0000);
        send_item(CMD_XFORM, 0, 0, 32'sh4000_0000, 32'shC000_0000);
        send_item(CMD_XFORM, 0, 0, 32'sh0001_0000, 32'shFFFF_0000);
        drain();
        cfg_write(REG_ORDER, 0);
        cfg_write(REG_Y_FLIP, 1);
        cfg_write(REG_X_REF, 32'h8000_0000);
        cfg_write(REG_Y_REF, 32'h7FFF_FFFF);
        send_item(CMD_XFORM, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(CMD_XFORM, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        drain();
        cfg_write(REG_ORDER, 7);
        send_item(CMD_XFORM, 0, 0, 32'sh1234_5678, 32'shF000_0000);
        send_item(CMD_XFORM, 0, 0, 32'sh0000_0000, 32'sh0000_0000);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            random_setup(ph + $urandom_range(7) * 8);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            if (ph == 4)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(negedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            random_items(115);
            drain();
        end
        cfg_write(REG_ORDER, 5);
        cfg_write(REG_Y_FLIP, 0);

        $display("sent %0d items, checked %0d points (%0d clipped)",
                 sent, board.checked, board.clipped);
        $display("covered orders 0..7, both y senses, idle and stall mixes, a long output hold");
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
